[sv/first_fit_heap_allocator_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Clocked, reset-qualified property checks.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Check that holds at every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("allocator check failed");

// Check that an antecedent leads to a consequent in the next cycle.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator sequencing check failed");

`endif

[sv/ffha_pkg.sv]
// ---------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator files.
// ---------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int MAX_CHUNKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_CHUNKS);
  localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);

  localparam logic       ACT_ALLOC = 1'b0;
  localparam logic       ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_REL = 2'd2;

  localparam logic       REG_HEAP_BASE = 1'b0;
  localparam logic       REG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [1:0]  status;
  } rsp_t;

  // One chunk table entry.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        busy;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[sv/ffha_ram.sv]
// ---------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/first_fit_heap_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over an address-ordered chunk table in RAM.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: an item (req_i) is taken when start is high and busy
//    is low. action 0 allocates request_size bytes, action 1 frees
//    release_address.
//  - Result: rsp_o is valid for exactly one cycle while done_o is high.
//    The receiver cannot stall; busy drops in the same cycle as done_o, so
//    a new item may be issued right alongside the result.
//  - Config: cfg_valid_i/cfg_ready_o write heap_base (index 0) or
//    heap_size (index 1). Either write rebuilds the heap as one free
//    chunk, or as none if heap_size is below HEADER_BYTES. cfg_ready_o
//    is high only while idle and start is low.
//  - Operation: the table lives in one RAM with a registered read. The
//    first-fit search reads one entry per cycle. An allocate that splits
//    then shifts the entries above the hit up by one (one entry per
//    cycle) and writes two entries; a free reads both neighbours and
//    shifts the tail down when it merges.
//  - Reset: heap_base and heap_size clear to 0, so there is no heap and the
//    chunk count is 0. RAM content beyond the count is never used, so no
//    clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ffha_pkg::req_t req_i,
  output logic               done_o,
  output ffha_pkg::rsp_t     rsp_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_SHUP = 8'b0000_0100,
    S_WRN  = 8'b0000_1000,
    S_WRI  = 8'b0001_0000,
    S_RDP  = 8'b0010_0000,
    S_RDN  = 8'b0100_0000,
    S_MRG  = 8'b1000_0000
  } state_e;

  // S_SHDN folded into a flag to keep the state set compact.
  state_e state_q, state_d;
  logic   shdn_q, shdn_d;

  logic [31:0]            base_q, base_d, size_q, size_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   act_q, act_d;
  logic [31:0]            req_q, req_d, rel_q, rel_d;
  logic [CW-1:0]          idx_q, idx_d, pidx_q, pidx_d;
  logic                   pend_q, pend_d;
  logic [IW-1:0]          fi_q, fi_d;
  ffha_pkg::entry_t       ent_q, ent_d, prev_q, prev_d;
  logic                   split_q, split_d;
  logic [1:0]             dist_q, dist_d;
  logic                   done_d;
  ffha_pkg::rsp_t         rsp_d;

  // RAM port
  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  ffha_pkg::entry_t       ram_wdata, ram_rdata;

  ffha_ram #(
    .WIDTH(ffha_pkg::ENTRY_W),
    .DEPTH(ffha_pkg::MAX_CHUNKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy        = (state_q != S_IDLE) || shdn_q;
  assign cfg_ready_o = !busy && !start;

  // Search-hit tests on the entry returned this cycle.
  logic        hit_alloc, hit_free, hit;
  logic [32:0] split_need;
  assign hit_alloc  = !ram_rdata.busy && (ram_rdata.len > req_q);
  assign hit_free   = ((ram_rdata.start + 32'(ffha_pkg::HEADER_BYTES)) == rel_q);
  assign hit        = pend_q && ((act_q == ffha_pkg::ACT_FREE) ? hit_free : hit_alloc);
  assign split_need = {1'b0, req_q} + 33'(ffha_pkg::HEADER_BYTES + 1);

  // Merge terms for a free.
  logic        prev_free, next_free;
  logic [31:0] len_a, len_b;
  logic [CW-1:0] fi_ext;
  assign fi_ext    = CW'(fi_q);
  assign prev_free = (fi_q != '0) && !prev_q.busy;
  assign next_free = ((fi_ext + CW'(1)) < cnt_q) && !ram_rdata.busy;
  assign len_a     = prev_free ? (prev_q.len + ent_q.len + 32'(ffha_pkg::HEADER_BYTES))
                               : ent_q.len;
  assign len_b     = next_free ? (len_a + ram_rdata.len + 32'(ffha_pkg::HEADER_BYTES))
                               : len_a;

  logic issue_up, issue_dn;
  assign issue_up = idx_q > fi_ext;
  assign issue_dn = idx_q < cnt_q;

  always_comb begin
    state_d = state_q;
    shdn_d  = shdn_q;
    base_d  = base_q;
    size_d  = size_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    req_d   = req_q;
    rel_d   = rel_q;
    idx_d   = idx_q;
    pidx_d  = pidx_q;
    pend_d  = 1'b0;
    fi_d    = fi_q;
    ent_d   = ent_q;
    prev_d  = prev_q;
    split_d = split_q;
    dist_d  = dist_q;
    done_d  = 1'b0;
    rsp_d   = rsp_o;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[IW-1:0];

    if (shdn_q) begin
      // Pull the tail down by dist_q entries.
      if (issue_dn) begin
        ram_re = 1'b1;
        idx_d  = idx_q + CW'(1);
        pidx_d = idx_q;
        pend_d = 1'b1;
      end
      if (pend_q) begin
        ram_we    = 1'b1;
        ram_waddr = IW'(pidx_q - CW'(dist_q));
        ram_wdata = ram_rdata;
      end
      if (!issue_dn && !pend_q) begin
        shdn_d = 1'b0;
        cnt_d  = cnt_q - CW'(dist_q);
        done_d = 1'b1;
        rsp_d  = '{data_address: '0, status: ffha_pkg::ST_OK};
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            act_d   = req_i.action;
            req_d   = req_i.request_size;
            rel_d   = req_i.release_address;
            idx_d   = '0;
            state_d = S_SCAN;
          end else if (cfg_valid_i) begin
            // Rebuild as one free chunk (none if the size is below the header).
            if (cfg_index_i == ffha_pkg::REG_HEAP_BASE) base_d = cfg_data_i;
            else                                        size_d = cfg_data_i;
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{start: base_d, len: size_d - 32'(ffha_pkg::HEADER_BYTES),
                          busy: 1'b0};
            cnt_d     = (size_d < 32'(ffha_pkg::HEADER_BYTES)) ? '0 : CW'(1);
          end
        end
        S_SCAN: begin
          if (issue_dn) begin
            ram_re = 1'b1;
            idx_d  = idx_q + CW'(1);
            pidx_d = idx_q;
            pend_d = 1'b1;
          end
          if (hit) begin
            pend_d = 1'b0;
            fi_d   = pidx_q[IW-1:0];
            ent_d  = ram_rdata;
            if (act_q == ffha_pkg::ACT_FREE) begin
              if (!ram_rdata.busy) begin
                state_d = S_IDLE;
                done_d  = 1'b1;
                rsp_d   = '{data_address: '0, status: ffha_pkg::ST_BAD_REL};
              end else begin
                state_d = S_RDP;
              end
            end else begin
              split_d = ({1'b0, ram_rdata.len} >= split_need) &&
                        (cnt_q < CW'(ffha_pkg::MAX_CHUNKS));
              idx_d   = cnt_q - CW'(1);
              state_d = (({1'b0, ram_rdata.len} >= split_need) &&
                         (cnt_q < CW'(ffha_pkg::MAX_CHUNKS))) ? S_SHUP : S_WRI;
            end
          end else if (!pend_q && !issue_dn) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
            rsp_d   = (act_q == ffha_pkg::ACT_FREE)
                    ? '{data_address: '0, status: ffha_pkg::ST_BAD_REL}
                    : '{data_address: '0, status: ffha_pkg::ST_NO_FIT};
          end
        end
        S_SHUP: begin
          // Open a slot at fi+1: move entries up, highest first.
          if (issue_up) begin
            ram_re = 1'b1;
            idx_d  = idx_q - CW'(1);
            pidx_d = idx_q;
            pend_d = 1'b1;
          end
          if (pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(pidx_q + CW'(1));
            ram_wdata = ram_rdata;
          end
          if (!issue_up && !pend_q) state_d = S_WRN;
        end
        S_WRN: begin
          ram_we    = 1'b1;
          ram_waddr = fi_q + IW'(1);
          ram_wdata = '{start: ent_q.start + 32'(ffha_pkg::HEADER_BYTES) + req_q,
                        len:   ent_q.len - req_q - 32'(ffha_pkg::HEADER_BYTES),
                        busy:  1'b0};
          state_d   = S_WRI;
        end
        S_WRI: begin
          ram_we    = 1'b1;
          ram_waddr = fi_q;
          ram_wdata = '{start: ent_q.start, len: split_q ? req_q : ent_q.len, busy: 1'b1};
          cnt_d     = cnt_q + CW'(split_q);
          state_d   = S_IDLE;
          done_d    = 1'b1;
          rsp_d     = '{data_address: ent_q.start + 32'(ffha_pkg::HEADER_BYTES),
                        status: ffha_pkg::ST_OK};
        end
        S_RDP: begin
          ram_re    = 1'b1;
          ram_raddr = fi_q - IW'(1);
          state_d   = S_RDN;
        end
        S_RDN: begin
          prev_d    = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = fi_q + IW'(1);
          state_d   = S_MRG;
        end
        S_MRG: begin
          ram_we    = 1'b1;
          ram_waddr = prev_free ? (fi_q - IW'(1)) : fi_q;
          ram_wdata = '{start: prev_free ? prev_q.start : ent_q.start, len: len_b,
                        busy: 1'b0};
          dist_d    = {1'b0, prev_free} + {1'b0, next_free};
          idx_d     = fi_ext + CW'(1) + CW'(next_free);
          state_d   = S_IDLE;
          if (prev_free || next_free) begin
            shdn_d = 1'b1;
          end else begin
            done_d = 1'b1;
            rsp_d  = '{data_address: '0, status: ffha_pkg::ST_OK};
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      shdn_q  <= 1'b0;
      base_q  <= '0;
      size_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      shdn_q  <= shdn_d;
      base_q  <= base_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    req_q   <= req_d;
    rel_q   <= rel_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    fi_q    <= fi_d;
    ent_q   <= ent_d;
    prev_q  <= prev_d;
    split_q <= split_d;
    dist_q  <= dist_d;
    rsp_o   <= rsp_d;
  end

endmodule

`default_nettype wire

[sv/ffha_checker.sv]
// ---------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire ffha_pkg::rsp_t rsp_o,
  input wire logic           cfg_ready_o
);

  `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FFHA_ASSERT(a_done_idle, done_o |-> !busy)
  `FFHA_ASSERT(a_fail_zero, (done_o && rsp_o.status != ffha_pkg::ST_OK) |-> (rsp_o.data_address == '0))
  `FFHA_ASSERT(a_status_code, done_o |-> (rsp_o.status != 2'd3))
  `FFHA_ASSERT(a_cfg_idle, cfg_ready_o |-> !busy)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .rsp_o      (rsp_o),
  .cfg_ready_o(cfg_ready_o)
);

`default_nettype wire
